// ----- src/cdconv_pkg.sv -----
package cdconv_pkg;

  localparam int MaxIn      = 16;
  localparam int MaxOut     = 16;
  localparam int MaxTaps    = 8;
  localparam int MaxDil     = 16;
  localparam int FracBits   = 12;
  localparam int HistSteps  = 128;

  localparam int HistDepth   = HistSteps * MaxIn;
  localparam int WeightDepth = MaxOut * MaxIn * MaxTaps;
  localparam int HistAw      = $clog2(HistDepth);
  localparam int WeightAw    = $clog2(WeightDepth);
  localparam int StepW       = $clog2(HistSteps);
  localparam int ChW         = $clog2(MaxIn);
  localparam int CoW         = $clog2(MaxOut);
  localparam int KiW         = $clog2(MaxTaps);
  localparam int AccW        = 44;

  typedef enum logic [1:0] {
    ActPush   = 2'd0,
    ActWeight = 2'd1,
    ActBias   = 2'd2,
    ActNone   = 2'd3
  } action_e;

  localparam logic [2:0] CfgInCh   = 3'd0;
  localparam logic [2:0] CfgOutCh  = 3'd1;
  localparam logic [2:0] CfgTaps   = 3'd2;
  localparam logic [2:0] CfgSpacing = 3'd3;

  function automatic logic [4:0] clamp_cfg(input logic [4:0] v, input logic [4:0] hi);
    logic [4:0] r;
    if (v == 5'd0) begin
      r = 5'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- src/cdconv_ram.sv -----
module cdconv_ram #(
  parameter int Width = 16,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/cdconv_cell.sv -----
module cdconv_cell (
  input  logic                                clk_i,
  input  logic                                shift_i,
  input  logic signed [cdconv_pkg::AccW-1:0]  acc_i,
  output logic signed [cdconv_pkg::AccW-1:0]  acc_o
);

  logic signed [cdconv_pkg::AccW-1:0] acc_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      acc_q <= acc_i;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- src/causal_dilated_conv1d_top.sv -----
// Channel | Handshake                | Payload
// in      | in_valid_i / in_stall_o  | action, sample, new_sequence, entry_index, weight, bias
// out     | out_valid_o / out_stall_i| out_channel, result, saturated, last
// cfg     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
// Weight and bias writes are taken in S_IDLE; a sample that does not end a step visits S_WRITE.
// A step-ending sample runs S_BIAS, S_HREAD/S_HWAIT/S_MAC per tap and channel, S_FLUSH and
// S_OUT, at a pace set by the single shared multiplier and the accumulator ring of cout cells.
// After reset and on new_sequence, a clearing pass over all 2048 entries zeroes history.
// Results wait in an output register; a stalled output holds the drain of the ring.
module causal_dilated_conv1d_top (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [1:0]           action_i,
  input  logic signed [15:0]   sample_i,
  input  logic                 new_sequence_i,
  input  logic [10:0]          entry_index_i,
  input  logic signed [15:0]   weight_i,
  input  logic signed [31:0]   bias_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [3:0]           out_channel_o,
  output logic signed [15:0]   result_o,
  output logic                 saturated_o,
  output logic                 last_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [2:0]           cfg_index_i,
  input  logic [4:0]           cfg_data_i
);

  localparam int AccW = cdconv_pkg::AccW;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_WRITE, S_BIAS, S_HREAD, S_HWAIT, S_MAC, S_FLUSH, S_OUT
  } state_e;

  state_e state_q;
  logic [cdconv_pkg::HistAw-1:0]   clr_q;
  logic                            pend_q;
  logic [4:0]                      cin_q, cout_q, dil_q;
  logic [3:0]                      taps_q;
  logic [cdconv_pkg::ChW-1:0]      cc_q, ci_q;
  logic [cdconv_pkg::StepW-1:0]    tp_q, hstep_q;
  logic [cdconv_pkg::CoW-1:0]      co_q;
  logic [cdconv_pkg::KiW-1:0]      ki_q;
  logic [cdconv_pkg::WeightAw-1:0] base_q, waddr_q, stride_q;
  logic signed [15:0]              sample_q, x_q;
  logic signed [31:0]              bias_q [cdconv_pkg::MaxOut];
  logic signed [31:0]              prod_q;
  logic                            p1_q, p2_q;
  logic                            out_valid_q, sat_q, last_q;
  logic [3:0]                      out_ch_q;
  logic signed [15:0]              res_q;

  logic in_acc, out_load, rot_en;
  logic [8:0] span;
  logic signed [AccW-1:0] head_d, tail;
  logic signed [AccW-1:0] ring [cdconv_pkg::MaxOut];
  logic signed [AccW-cdconv_pkg::FracBits-1:0] shifted;

  logic                             hist_we, hist_re;
  logic [cdconv_pkg::HistAw-1:0]    hist_waddr;
  logic [15:0]                      hist_wdata, hist_rdata, w_rdata;

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_load    = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);
  assign span        = 9'(taps_q - 4'd1) * 9'(dil_q);

  assign hist_we    = (state_q == S_CLEAR) || (state_q == S_WRITE);
  assign hist_waddr = (state_q == S_CLEAR) ? clr_q : {tp_q, cc_q};
  assign hist_wdata = (state_q == S_CLEAR) ? 16'd0 : sample_q;
  assign hist_re    = (state_q == S_HREAD);

  cdconv_ram #(.Width(16), .Depth(cdconv_pkg::HistDepth)) u_hist (
    .clk_i   (clk_i),
    .we_i    (hist_we),
    .waddr_i (hist_waddr),
    .wdata_i (hist_wdata),
    .re_i    (hist_re),
    .raddr_i ({hstep_q, ci_q}),
    .rdata_o (hist_rdata)
  );

  cdconv_ram #(.Width(16), .Depth(cdconv_pkg::WeightDepth)) u_weight (
    .clk_i   (clk_i),
    .we_i    (in_acc && (action_i == cdconv_pkg::ActWeight)),
    .waddr_i (entry_index_i),
    .wdata_i (weight_i),
    .re_i    (state_q == S_MAC),
    .raddr_i (waddr_q),
    .rdata_o (w_rdata)
  );

  // accumulator ring: head takes the tail plus a product, or a bias, or the tail itself while draining
  assign tail = ring[4'(cout_q - 5'd1)];
  always_comb begin
    rot_en = 1'b0;
    head_d = tail;
    if (state_q == S_BIAS) begin
      rot_en = 1'b1;
      head_d = AccW'(bias_q[co_q]);
    end else if (p2_q) begin
      rot_en = 1'b1;
      head_d = tail + AccW'(prod_q);
    end else if (out_load) begin
      rot_en = 1'b1;
    end
  end

  for (genvar i = 0; i < cdconv_pkg::MaxOut; i++) begin : g_ring
    cdconv_cell u_cell (
      .clk_i   (clk_i),
      .shift_i (rot_en),
      .acc_i   ((i == 0) ? head_d : ring[(i == 0) ? 0 : i - 1]),
      .acc_o   (ring[i])
    );
  end

  assign shifted = tail[AccW-1:cdconv_pkg::FracBits];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      pend_q      <= 1'b0;
      cin_q       <= 5'd1;
      cout_q      <= 5'd1;
      taps_q      <= 4'd1;
      dil_q       <= 5'd1;
      cc_q        <= '0;
      tp_q        <= '0;
      ci_q        <= '0;
      ki_q        <= '0;
      co_q        <= '0;
      p1_q        <= 1'b0;
      p2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          cdconv_pkg::CfgInCh:    cin_q  <= cdconv_pkg::clamp_cfg(cfg_data_i,
                                                                  5'(cdconv_pkg::MaxIn));
          cdconv_pkg::CfgOutCh:   cout_q <= cdconv_pkg::clamp_cfg(cfg_data_i,
                                                                  5'(cdconv_pkg::MaxOut));
          cdconv_pkg::CfgTaps:    taps_q <= 4'(cdconv_pkg::clamp_cfg({1'b0, cfg_data_i[3:0]},
                                                                      5'(cdconv_pkg::MaxTaps)));
          cdconv_pkg::CfgSpacing: dil_q  <= cdconv_pkg::clamp_cfg(cfg_data_i,
                                                                  5'(cdconv_pkg::MaxDil));
          default: ;
        endcase
      end

      p1_q <= (state_q == S_MAC);
      p2_q <= p1_q;
      if (p1_q) begin
        prod_q <= $signed(w_rdata) * x_q;
      end

      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end

      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (&clr_q) begin
            cc_q    <= '0;
            tp_q    <= '0;
            state_q <= pend_q ? S_WRITE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_acc) begin
            case (action_i)
              cdconv_pkg::ActPush: begin
                sample_q <= sample_i;
                if (new_sequence_i) begin
                  pend_q  <= 1'b1;
                  clr_q   <= '0;
                  state_q <= S_CLEAR;
                end else begin
                  state_q <= S_WRITE;
                end
              end
              cdconv_pkg::ActBias: begin
                if (entry_index_i < 11'(cdconv_pkg::MaxOut)) begin
                  bias_q[entry_index_i[3:0]] <= bias_i;
                end
              end
              default: ;
            endcase
          end
        end
        S_WRITE: begin
          pend_q <= 1'b0;
          if (({1'b0, cc_q} + 5'd1) < cin_q) begin
            cc_q    <= cc_q + 1'b1;
            state_q <= S_IDLE;
          end else begin
            cc_q     <= '0;
            co_q     <= '0;
            ki_q     <= '0;
            ci_q     <= '0;
            base_q   <= '0;
            stride_q <= 11'(9'(cin_q) * 9'(taps_q));
            hstep_q  <= tp_q - span[6:0];
            state_q  <= S_BIAS;
          end
        end
        S_BIAS: begin
          co_q <= co_q + 1'b1;
          if (({1'b0, co_q} + 5'd1) == cout_q) begin
            co_q    <= '0;
            state_q <= S_HREAD;
          end
        end
        S_HREAD: begin
          state_q <= S_HWAIT;
        end
        S_HWAIT: begin
          x_q     <= hist_rdata;
          waddr_q <= base_q;
          co_q    <= '0;
          state_q <= S_MAC;
        end
        S_MAC: begin
          waddr_q <= waddr_q + stride_q;
          co_q    <= co_q + 1'b1;
          if (({1'b0, co_q} + 5'd1) == cout_q) begin
            co_q   <= '0;
            base_q <= base_q + 1'b1;
            if (({1'b0, ci_q} + 5'd1) < cin_q) begin
              ci_q    <= ci_q + 1'b1;
              state_q <= S_HREAD;
            end else begin
              ci_q    <= '0;
              hstep_q <= hstep_q + {2'b00, dil_q};
              if (({1'b0, ki_q} + 4'd1) < taps_q) begin
                ki_q    <= ki_q + 1'b1;
                state_q <= S_HREAD;
              end else begin
                state_q <= S_FLUSH;
              end
            end
          end
        end
        S_FLUSH: begin
          if (!p1_q && !p2_q) begin
            co_q    <= '0;
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_ch_q    <= co_q;
            last_q      <= (({1'b0, co_q} + 5'd1) == cout_q);
            if (shifted > 32'sd32767) begin
              res_q <= 16'sh7fff;
              sat_q <= 1'b1;
            end else if (shifted < -32'sd32768) begin
              res_q <= -16'sd32768;
              sat_q <= 1'b1;
            end else begin
              res_q <= shifted[15:0];
              sat_q <= 1'b0;
            end
            co_q <= co_q + 1'b1;
            if (({1'b0, co_q} + 5'd1) == cout_q) begin
              co_q    <= '0;
              tp_q    <= tp_q + 1'b1;
              state_q <= S_IDLE;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_ch_q;
  assign result_o      = res_q;
  assign saturated_o   = sat_q;
  assign last_o        = last_q;

endmodule
